### hw/rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants for the LRU key/value table
// Table geometry, field widths, command codes, controller states and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package lrukv_pkg;

   // Table geometry
   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int GROUP_SIZE = 4;
   localparam int GROUPS     = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 64;
   localparam int SID_W   = 8;
   localparam int SLOT_W  = 4;
   localparam int STAMP_W = 48;

   // Request operations; the fourth code is unused and changes nothing
   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;    // capture a new request item
      logic load_search; // register match vectors and per-group minimum stamps
      logic commit;      // update the table and load the result register
   } dp_cmd_type;

endpackage

### hw/rtl/lrukv_ctrl.sv
// ----------------------------------------------------------------------------
// lrukv_ctrl: request sequencer for the LRU key/value table
// Steps each item through search and update, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lrukv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lrukv_pkg::dp_cmd_type dp_cmd
);

   lrukv_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 can_commit;

   // result slot is free or being emptied this cycle
   assign can_commit = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            if (req_valid) state_in = lrukv_pkg::ST_SEARCH;
         end
         lrukv_pkg::ST_SEARCH: begin
            state_in = lrukv_pkg::ST_UPDATE;
         end
         lrukv_pkg::ST_UPDATE: begin
            if (can_commit) begin
               state_in = req_valid ? lrukv_pkg::ST_SEARCH : lrukv_pkg::ST_IDLE;
            end
         end
         default: state_in = lrukv_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready          = 1'b0;
      dp_cmd.load_search = 1'b0;
      dp_cmd.commit      = 1'b0;
      case (state_ff)
         lrukv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         lrukv_pkg::ST_SEARCH: begin
            dp_cmd.load_search = 1'b1;
         end
         lrukv_pkg::ST_UPDATE: begin
            req_ready     = can_commit;
            dp_cmd.commit = can_commit;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      dp_cmd.load_req = req_valid && req_ready;
   end

   // result valid flag
   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrukv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/lrukv_dp.sv
// ----------------------------------------------------------------------------
// lrukv_dp: slot storage, key match, victim search and result register
// Search registers the match/free vectors and per-group oldest slots; update
// picks the final slot, writes the table and loads the result.
// ----------------------------------------------------------------------------
module lrukv_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lrukv_pkg::dp_cmd_type          dp_cmd,
   input  logic [lrukv_pkg::CMD_W-1:0]    req_cmd,
   input  logic [lrukv_pkg::KEY_W-1:0]    req_key,
   input  logic [lrukv_pkg::SID_W-1:0]    req_server_id,
   output logic                           rsp_hit,
   output logic [lrukv_pkg::SID_W-1:0]    rsp_found_server,
   output logic [lrukv_pkg::SLOT_W-1:0]   rsp_slot
);

   localparam int N  = lrukv_pkg::ENTRIES;
   localparam int IW = lrukv_pkg::IDX_W;
   localparam int G  = lrukv_pkg::GROUPS;
   localparam int GS = lrukv_pkg::GROUP_SIZE;
   localparam int SW = lrukv_pkg::STAMP_W;

   // slot table
   logic [N-1:0]                      valid_ff;
   logic [lrukv_pkg::KEY_W-1:0]       key_ff    [N];
   logic [lrukv_pkg::SID_W-1:0]       server_ff [N];
   logic [SW-1:0]                     stamp_ff  [N];
   logic [SW-1:0]                     counter_ff;

   // request item
   lrukv_pkg::cmd_type                cmd_ff;
   logic [lrukv_pkg::KEY_W-1:0]       key_req_ff;
   logic [lrukv_pkg::SID_W-1:0]       sid_req_ff;

   // search stage
   logic [N-1:0]                      match_ff, match_in;
   logic [N-1:0]                      free_ff, free_in;
   logic [IW-1:0]                     grp_idx_ff   [G];
   logic [IW-1:0]                     grp_idx_in   [G];
   logic [SW-1:0]                     grp_stamp_ff [G];
   logic [SW-1:0]                     grp_stamp_in [G];

   // result register
   logic                              hit_ff, hit_in;
   logic [lrukv_pkg::SID_W-1:0]       found_ff, found_in;
   logic [lrukv_pkg::SLOT_W-1:0]      slot_ff, slot_in;

   // update stage decisions
   logic [IW-1:0]                     match_idx, free_idx, oldest_idx, victim_idx;
   logic [SW-1:0]                     oldest_stamp;
   logic                              any_match, any_free;
   logic [SW-1:0]                     stamp_next;
   logic                              wr_touch, wr_insert, wr_remove;
   logic [IW-1:0]                     wr_idx;

   // request capture
   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff     <= lrukv_pkg::cmd_type'(req_cmd);
         key_req_ff <= req_key;
         sid_req_ff <= req_server_id;
      end
   end

   // key compare and free slots, all slots in parallel
   always_comb begin
      for (int i = 0; i < N; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == key_req_ff);
         free_in[i]  = !valid_ff[i];
      end
   end

   // oldest slot within each group, lowest index wins a tie
   always_comb begin
      for (int g = 0; g < G; g++) begin
         grp_idx_in[g]   = IW'(g * GS);
         grp_stamp_in[g] = stamp_ff[g * GS];
         for (int j = 1; j < GS; j++) begin
            if ((g * GS + j) < N) begin
               if (stamp_ff[g * GS + j] < grp_stamp_in[g]) begin
                  grp_idx_in[g]   = IW'(g * GS + j);
                  grp_stamp_in[g] = stamp_ff[g * GS + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_search) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         for (int g = 0; g < G; g++) begin
            grp_idx_ff[g]   <= grp_idx_in[g];
            grp_stamp_ff[g] <= grp_stamp_in[g];
         end
      end
   end

   // lowest matching and lowest free slot
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match_ff[i]) match_idx = IW'(i);
         if (free_ff[i])  free_idx  = IW'(i);
      end
      any_match = |match_ff;
      any_free  = |free_ff;
   end

   // oldest over the group winners
   always_comb begin
      oldest_idx   = grp_idx_ff[0];
      oldest_stamp = grp_stamp_ff[0];
      for (int g = 1; g < G; g++) begin
         if (grp_stamp_ff[g] < oldest_stamp) begin
            oldest_idx   = grp_idx_ff[g];
            oldest_stamp = grp_stamp_ff[g];
         end
      end
   end

   assign victim_idx = any_free ? free_idx : oldest_idx;
   assign stamp_next = counter_ff + SW'(1);

   // decide the table write and the result item
   always_comb begin
      wr_touch  = 1'b0;
      wr_insert = 1'b0;
      wr_remove = 1'b0;
      wr_idx    = match_idx;
      hit_in    = 1'b0;
      found_in  = '0;
      slot_in   = '0;
      case (cmd_ff)
         lrukv_pkg::CMD_LOOKUP: begin
            if (any_match) begin
               wr_touch = 1'b1;
               hit_in   = 1'b1;
               found_in = server_ff[match_idx];
               slot_in  = lrukv_pkg::SLOT_W'(match_idx);
            end
         end
         lrukv_pkg::CMD_INSERT: begin
            wr_insert = 1'b1;
            wr_idx    = victim_idx;
            slot_in   = lrukv_pkg::SLOT_W'(victim_idx);
         end
         lrukv_pkg::CMD_REMOVE: begin
            if (any_match) begin
               wr_remove = 1'b1;
               hit_in    = 1'b1;
               slot_in   = lrukv_pkg::SLOT_W'(match_idx);
            end
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   // valid bits, stamps and use counter
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         counter_ff <= '0;
         for (int i = 0; i < N; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (dp_cmd.commit) begin
         if (wr_touch || wr_insert) begin
            counter_ff       <= stamp_next;
            stamp_ff[wr_idx] <= stamp_next;
         end
         if (wr_insert) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (wr_remove) begin
            valid_ff[wr_idx] <= 1'b0;
            stamp_ff[wr_idx] <= '0;
         end
      end
   end

   // key and server id payload
   always_ff @(posedge clock) begin
      if (dp_cmd.commit && wr_insert) begin
         key_ff[wr_idx]    <= key_req_ff;
         server_ff[wr_idx] <= sid_req_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         hit_ff   <= hit_in;
         found_ff <= found_in;
         slot_ff  <= slot_in;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_found_server = found_ff;
   assign rsp_slot         = slot_ff;

endmodule

### hw/rtl/lru_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_table_unit: fully associative key/value table with LRU refill
// Top level joining the request sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Each request item (lookup, insert or remove) produces exactly one result
// item. The search step compares the key against every slot and registers
// the oldest stamp of each group of four slots; the update step finishes
// the oldest-slot pick, writes the table and loads the result register. With
// the result channel ready the next item is accepted in the same cycle the
// previous one commits, and a waiting result only holds the block once a
// second result is ready to go.
// Insert fills the lowest free slot, else the slot with the smallest stamp
// (lowest index on a tie); lookup and remove act on the lowest matching slot.
// ----------------------------------------------------------------------------
module lru_key_value_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lrukv_pkg::CMD_W-1:0]    req_cmd,
   input  logic [lrukv_pkg::KEY_W-1:0]    req_key,
   input  logic [lrukv_pkg::SID_W-1:0]    req_server_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic [lrukv_pkg::SID_W-1:0]    rsp_found_server,
   output logic [lrukv_pkg::SLOT_W-1:0]   rsp_slot
);

   lrukv_pkg::dp_cmd_type dp_cmd;

   lrukv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   lrukv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_server_id    (req_server_id),
      .rsp_hit          (rsp_hit),
      .rsp_found_server (rsp_found_server),
      .rsp_slot         (rsp_slot)
   );

endmodule
